// ===== rtl/core/bdac_pkg.sv =====
// shared constants and types for the binary to decimal ascii converter
package bdac_pkg;

  localparam int unsigned VALUE_BITS = 32;
  // decimal digits needed for the largest value: floor(bits * log10(2)) + 1
  localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam int unsigned CHAR_W     = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef logic [3:0] bcd_digit_t;

  typedef struct packed {
    logic clear;
    logic shift_bin;
    logic shift_dig;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/bdac_if.sv =====
// handshake channels for the binary to decimal ascii converter
interface bdac_in_if import bdac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
  modport mon    (input valid, input value, input ready);
endinterface

interface bdac_out_if import bdac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
  modport mon    (input valid, input digit_char, input last_digit, input ready);
endinterface

// ===== rtl/core/binary_to_decimal_ascii_unit.sv =====
// top level: binary value in, decimal ascii digits out, most significant first
//
//  channel | dir | payload                  | transaction
//  in_i    | in  | value[VALUE_BITS-1:0]    | one number to convert
//  out_o   | out | digit_char[5:0], last    | one ascii digit, last marks the end
//
// an accepted value is shifted bit by bit through the digit cells, most significant
// bit first; then each of the NUM_DIGITS digit positions (10 at the default width)
// either drops a leading zero or hands one digit to the output register.
// a stalled output holds the digit walk; in_i is ready again once the last digit
// sits in the output register. reset clears the sequencer and the output valid.
module binary_to_decimal_ascii_unit import bdac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdac_in_if.sink     in_i,
  bdac_out_if.source  out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]  dig_cnt_q, dig_cnt_d;
  logic                  started_q, started_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     char_q, char_d;
  logic                  last_q, last_d;

  cell_ctrl_t            cell_ctrl;
  logic                  in_fire, slot_free, skip, emit;
  bcd_digit_t            top_digit;

  logic       carry [NUM_DIGITS+1];
  bcd_digit_t digit [NUM_DIGITS+1];

  assign carry[0] = bin_q[VALUE_BITS-1];
  assign digit[0] = '0;

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    bdac_digit_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .carry_i (carry[g]),
      .digit_i (digit[g]),
      .carry_o (carry[g+1]),
      .digit_o (digit[g+1])
    );
  end

  assign top_digit   = digit[NUM_DIGITS];
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign slot_free   = !out_valid_q || out_o.ready;

  // drop leading zeros, but never the units digit
  assign skip = (state_q == ST_EMIT) && !started_q && (top_digit == '0)
                && (dig_cnt_q > DIG_CNT_W'(1));
  assign emit = (state_q == ST_EMIT) && !skip && slot_free;

  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    started_d   = started_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    cell_ctrl   = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          bin_d           = in_i.value;
          bit_cnt_d       = BIT_CNT_W'(VALUE_BITS);
          started_d       = 1'b0;
          cell_ctrl.clear = 1'b1;
          state_d         = ST_CONV;
        end
      end
      ST_CONV: begin
        cell_ctrl.shift_bin = 1'b1;
        bin_d               = bin_q << 1;
        bit_cnt_d           = bit_cnt_q - BIT_CNT_W'(1);
        if (bit_cnt_q == BIT_CNT_W'(1)) begin
          dig_cnt_d = DIG_CNT_W'(NUM_DIGITS);
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip || emit) begin
          cell_ctrl.shift_dig = 1'b1;
          dig_cnt_d           = dig_cnt_q - DIG_CNT_W'(1);
        end
        if (emit) begin
          started_d   = 1'b1;
          out_valid_d = 1'b1;
          char_d      = ASCII_ZERO | CHAR_W'(top_digit);
          last_d      = (dig_cnt_q == DIG_CNT_W'(1));
          if (dig_cnt_q == DIG_CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.digit_char = char_q;
  assign out_o.last_digit = last_q;

endmodule

// ===== rtl/core/bdac_digit_cell.sv =====
// one bcd digit of the double dabble chain
module bdac_digit_cell import bdac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       carry_i,
  input  bcd_digit_t digit_i,
  output logic       carry_o,
  output bcd_digit_t digit_o
);

  bcd_digit_t digit_q, digit_d;
  bcd_digit_t adj;

  // add three before the shift so the digit never passes nine
  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    priority if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift_bin) begin
      digit_d = {adj[2:0], carry_i};
    end else if (ctrl_i.shift_dig) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

// ===== rtl/core/bdac_checker.sv =====
// port-level checks for the binary to decimal ascii converter, bound to the top level
module bdac_checker import bdac_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CHAR_W-1:0] digit_char_i,
  input logic              last_digit_i
);

  // a stalled digit keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(digit_char_i)
      && $stable(last_digit_i))
    else $error("output payload changed while stalled");

  // a digit is always an ascii decimal character
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> digit_char_i[5:4] == 2'b11 && digit_char_i[3:0] <= 4'd9)
    else $error("digit character out of range");

  // the block is busy right after taking a value
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready straight after a transaction");

  // while a digit other than the last one is held, no new value is taken
  a_busy_mid_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_digit_i |-> !in_ready_i)
    else $error("input ready before the last digit");

endmodule

bind binary_to_decimal_ascii_unit bdac_checker u_bdac_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .digit_char_i (out_o.digit_char),
  .last_digit_i (out_o.last_digit)
);

// ===== dv/bdac_digit_checker.sv =====
// checker for the converter: predicts the digit characters of each value and compares them
module bdac_digit_checker import bdac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdac_in_if.mon      in_mon_i,
  bdac_out_if.mon     out_mon_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned digits_o
);

  localparam int unsigned RADIX = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } ascii_digit_t;

  ascii_digit_t digits_due [$];

  // queues the characters of one value, most significant first
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] rest;
    bcd_digit_t            dig [$];
    rest = value;
    do begin
      dig.push_front(bcd_digit_t'(rest % RADIX));
      rest = rest / RADIX;
    end while (rest != 0);
    foreach (dig[k]) begin
      digits_due.push_back('{ch: ASCII_ZERO + CHAR_W'(dig[k]), last: (k == dig.size() - 1)});
    end
  endfunction

  always @(posedge clk_i) begin
    ascii_digit_t want;
    if (rst_ni) begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        predict_digits(in_mon_i.value);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        digits_o = digits_o + 1;
        if (digits_due.size() == 0) begin
          fail_cnt_o = fail_cnt_o + 1;
          $display("%0t: unexpected digit: expected none, actual char %0d last %0b",
                   $time, out_mon_i.digit_char, out_mon_i.last_digit);
        end else begin
          want = digits_due.pop_front();
          if (out_mon_i.digit_char !== want.ch) begin
            fail_cnt_o = fail_cnt_o + 1;
            $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                     $time, want.ch, out_mon_i.digit_char);
          end
          if (out_mon_i.last_digit !== want.last) begin
            fail_cnt_o = fail_cnt_o + 1;
            $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                     $time, want.last, out_mon_i.last_digit);
          end
        end
      end
      pending_o = digits_due.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// top of the converter testbench: clock, reset, value stimulus, output stalls and verdict
module testbench;
  import bdac_pkg::*;

  typedef enum logic [1:0] {
    ALWAYS_READY,
    COIN_FLIP,
    MOSTLY_STALLED,
    LONG_STALLS
  } stall_mode_e;

  localparam int unsigned RANDOM_VALUES = 89;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  src_valid = 1'b0;
  logic [VALUE_BITS-1:0] src_value = '0;
  logic                  sink_ready = 1'b0;
  logic [9:0]            stall_cyc = '0;

  int unsigned burst_left = 0;
  int unsigned values_sent = 0;
  int unsigned directed_cnt = 0;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned digits_seen;

  bdac_in_if  in_if ();
  bdac_out_if out_if ();

  assign in_if.valid  = src_valid;
  assign in_if.value  = src_value;
  assign out_if.ready = sink_ready;

  binary_to_decimal_ascii_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  bdac_digit_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon_i   (in_if.mon),
    .out_mon_i  (out_if.mon),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .digits_o   (digits_seen)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // output stalls: the pattern steps through the four stall modes in turn
  always @(posedge clk_i) begin
    stall_cyc <= stall_cyc + 1'b1;
    case (stall_mode_e'(stall_cyc[9:8]))
      ALWAYS_READY:   sink_ready <= 1'b1;
      COIN_FLIP:      sink_ready <= 1'($urandom_range(1, 0));
      MOSTLY_STALLED: sink_ready <= ($urandom_range(3, 0) == 0);
      default:        sink_ready <= ((stall_cyc % 24) >= 20);
    endcase
  end

  // bursts of back-to-back values with random gaps between them
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(8, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 1);
      if (gap != 0) begin
        src_valid <= 1'b0;
        src_value <= $urandom;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    src_valid <= 1'b1;
    src_value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    values_sent++;
  endtask

  // mostly picks a digit count first so short and long numbers are equally likely; one value in five is fully random
  function automatic logic [VALUE_BITS-1:0] pick_value();
    int unsigned n_dig;
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(4, 0) == 0) return $urandom;
    n_dig = $urandom_range(10, 1);
    lo = 1;
    repeat (n_dig - 1) lo = lo * 10;
    hi = (n_dig == 10) ? 32'hFFFF_FFFF : lo * 10 - 1;
    if (n_dig == 1) lo = 0;
    return $urandom_range(hi, lo);
  endfunction

  initial begin
    logic [VALUE_BITS-1:0] directed [$];
    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd1000,
                 32'd999999999, 32'd1000000000, 32'd1000000001, 32'd1234567890,
                 32'd2147483647, 32'd2147483648, 32'd3000000000, 32'd4000000000,
                 32'd4294967294, 32'd4294967295, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'd500000005};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[k]) send_value(directed[k]);
    directed_cnt = directed.size();
    repeat (RANDOM_VALUES) send_value(pick_value());
    src_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d values (%0d directed, the rest spread over all digit counts)",
             values_sent, directed_cnt);
    $display("checked %0d digits under sender bursts and four output stall patterns",
             digits_seen);
    if (fail_cnt == 0 && pending == 0) begin
      $display("binary_to_decimal_ascii_unit regression: pass");
    end else begin
      $display("binary_to_decimal_ascii_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("binary_to_decimal_ascii_unit regression: fail");
    $finish;
  end

endmodule
